// ----- src/wsclock_frame_sweep_unit_macros.svh -----
// Assertion macros for the frame sweep unit checker.
// No dependencies; included by the checker file.
`ifndef WSCLOCK_FRAME_SWEEP_UNIT_MACROS_SVH
`define WSCLOCK_FRAME_SWEEP_UNIT_MACROS_SVH

// Assertion sampled on the rising clock, off while reset is asserted.
`define WSFS_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Assertion sampled on the rising clock, active during reset as well.
`define WSFS_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ----- src/wsfs_pkg.sv -----
// Shared types, widths and constants of the frame sweep unit.
// Used by the controller, the datapath, the top level and the checker.
package wsfs_pkg;

	localparam int NUM_FRAMES = 8;
	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int IDX_W      = 6;
	localparam int TIME_W     = 31;
	localparam int CFG_IDX_W  = 1;
	localparam int START_CNT  = 2 ** IDX_W;

	localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(400);
	localparam logic [IDX_W-1:0]  START_RESET  = IDX_W'(3);

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME = CFG_IDX_W'(1);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SWEEP = 1'b1;

	typedef logic [FRAME_W-1:0] frame_t;
	typedef frame_t start_map_t [START_CNT];

	typedef struct packed {
		logic load;
		logic write;
		logic sweep;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic last_step;
		logic out_free;
		logic stall;
	} status_t;

	function automatic start_map_t build_start_map();
		start_map_t m;
		for (int i = 0; i < START_CNT; i++) begin
			m[i] = FRAME_W'(i % NUM_FRAMES);
		end
		return m;
	endfunction

	localparam start_map_t START_MAP = build_start_map();

endpackage

// ----- src/wsfs_ctrl.sv -----
// Controller of the frame sweep unit: sequences write, sweep and flush.
// Depends on wsfs_pkg for the command and status structs.
module wsfs_ctrl import wsfs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  logic    req_type,
	output logic    req_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WRITE = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_type == REQ_SWEEP) ? ST_SWEEP : ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (status.out_free) begin
					cmd.write = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (!status.stall && status.last_step) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/wsfs_datapath.sv -----
// Datapath of the frame sweep unit: frame store, hand, running time,
// pending result and output register. Depends on wsfs_pkg.
module wsfs_datapath import wsfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic                 req_type,
	input  logic [IDX_W-1:0]     frame_index,
	input  logic [TIME_W-1:0]    use_time,
	input  logic                 ref_bit,
	input  logic [TIME_W-1:0]    current_time,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [IDX_W-1:0]     victim_index,
	output logic [TIME_W-1:0]    stamp_time,
	output logic                 replaced,
	output logic                 is_last
);

	logic [TIME_W-1:0] window_q;
	logic [IDX_W-1:0]  start_q;

	logic [TIME_W-1:0] frame_lu_q  [NUM_FRAMES];
	logic              frame_ref_q [NUM_FRAMES];

	logic [IDX_W-1:0]  wr_idx_q;
	logic              wr_ref_q;
	logic [TIME_W-1:0] time_q;
	frame_t            start_used_q;
	frame_t            hand_q;
	frame_t            step_q;
	logic              pend_valid_q;
	frame_t            pend_idx_q;
	logic [TIME_W-1:0] pend_time_q;

	logic              rsp_valid_q;
	logic [IDX_W-1:0]  victim_q;
	logic [TIME_W-1:0] stamp_q;
	logic              replaced_q;
	logic              last_q;

	logic [TIME_W-1:0] cur_lu;
	logic              cur_ref;
	logic [TIME_W:0]   age;
	logic              aged;
	logic              out_free;
	logic              stall;
	logic              advance;
	logic              wr_in_ring;
	frame_t            hand_next;

	always_comb begin
		cur_lu     = frame_lu_q[hand_q];
		cur_ref    = frame_ref_q[hand_q];
		age        = {1'b0, time_q} - {1'b0, cur_lu};
		aged       = !cur_ref && !age[TIME_W] && (age[TIME_W-1:0] > window_q);
		out_free   = !rsp_valid_q || rsp_ready;
		stall      = aged && pend_valid_q && !out_free;
		advance    = cmd.sweep && !stall;
		wr_in_ring = {1'b0, wr_idx_q} < (IDX_W+1)'(NUM_FRAMES);
		hand_next  = (hand_q == FRAME_W'(NUM_FRAMES - 1)) ? '0 : hand_q + FRAME_W'(1);
		status.last_step = step_q == FRAME_W'(NUM_FRAMES - 1);
		status.out_free  = out_free;
		status.stall     = stall;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			start_q  <= START_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOW_SIZE: window_q <= cfg_data;
				CFG_START_FRAME: start_q  <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// frame store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES; i++) begin
				frame_lu_q[i]  <= '0;
				frame_ref_q[i] <= 1'b0;
			end
		end else if (cmd.write && wr_in_ring) begin
			frame_lu_q[wr_idx_q[FRAME_W-1:0]]  <= time_q;
			frame_ref_q[wr_idx_q[FRAME_W-1:0]] <= wr_ref_q;
		end else if (advance) begin
			if (cur_ref) begin
				frame_ref_q[hand_q] <= 1'b0;
			end else if (aged) begin
				frame_lu_q[hand_q]  <= time_q;
				frame_ref_q[hand_q] <= 1'b1;
			end
		end
	end

	// request fields, hand and running time
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wr_idx_q     <= frame_index;
			wr_ref_q     <= ref_bit;
			time_q       <= (req_type == REQ_SWEEP) ? current_time : use_time;
			start_used_q <= START_MAP[start_q];
			hand_q       <= START_MAP[start_q];
			step_q       <= '0;
		end else if (advance) begin
			hand_q <= hand_next;
			step_q <= step_q + FRAME_W'(1);
			if (aged) begin
				time_q      <= time_q + TIME_W'(1);
				pend_idx_q  <= hand_q;
				pend_time_q <= time_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.load) begin
			pend_valid_q <= 1'b0;
		end else if (advance && aged) begin
			pend_valid_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.write || cmd.flush || (advance && aged && pend_valid_q)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			victim_q   <= wr_idx_q;
			stamp_q    <= time_q;
			replaced_q <= 1'b0;
			last_q     <= 1'b1;
		end else if (cmd.flush) begin
			victim_q   <= pend_valid_q ? IDX_W'(pend_idx_q) : IDX_W'(start_used_q);
			stamp_q    <= pend_valid_q ? pend_time_q : time_q;
			replaced_q <= pend_valid_q;
			last_q     <= 1'b1;
		end else if (advance && aged && pend_valid_q) begin
			victim_q   <= IDX_W'(pend_idx_q);
			stamp_q    <= pend_time_q;
			replaced_q <= 1'b1;
			last_q     <= 1'b0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign victim_index = victim_q;
	assign stamp_time   = stamp_q;
	assign replaced     = replaced_q;
	assign is_last      = last_q;

endmodule

// ----- src/wsclock_frame_sweep_unit.sv -----
// Top level of the working-set clock frame sweep unit.
// Instantiates wsfs_ctrl and wsfs_datapath; depends on wsfs_pkg.
//
// A write word updates one frame if its index lies in the ring, and yields one
// acknowledge word. A sweep word walks the hand once around the NUM_FRAMES
// frame ring, one frame per cycle through the frame store while not stalled;
// each replaced frame gives one word, the last one marked, or a single
// unreplaced word if nothing aged out. Replacement words are held one deep
// before the output register, so a stalled output holds the hand at the next
// aged frame. A new request word is taken once the previous one has handed
// its last word to the output register, even if that word still waits.
// Configuration writes are always taken and must be issued while idle.
module wsclock_frame_sweep_unit import wsfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 req_type,
	input  logic [IDX_W-1:0]     frame_index,
	input  logic [TIME_W-1:0]    use_time,
	input  logic                 ref_bit,
	input  logic [TIME_W-1:0]    current_time,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [IDX_W-1:0]     victim_index,
	output logic [TIME_W-1:0]    stamp_time,
	output logic                 replaced,
	output logic                 is_last
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	wsfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	wsfs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.frame_index  (frame_index),
		.use_time     (use_time),
		.ref_bit      (ref_bit),
		.current_time (current_time),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.victim_index (victim_index),
		.stamp_time   (stamp_time),
		.replaced     (replaced),
		.is_last      (is_last)
	);

endmodule

// ----- src/wsfs_checker.sv -----
// Port-level checker of the frame sweep unit, bound to the top level.
// Depends on wsfs_pkg and wsclock_frame_sweep_unit_macros.svh.
`include "wsclock_frame_sweep_unit_macros.svh"

module wsfs_checker import wsfs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [IDX_W-1:0]     victim_index,
	input logic [TIME_W-1:0]    stamp_time,
	input logic                 replaced,
	input logic                 is_last
);

	property p_rsp_hold;
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(victim_index) && $stable(stamp_time)
			&& $stable(replaced) && $stable(is_last);
	endproperty

	property p_busy_after_accept;
		req_valid && req_ready |=> !req_ready;
	endproperty

	property p_plain_is_last;
		rsp_valid && !replaced |-> is_last;
	endproperty

	`WSFS_ASSERT(a_rsp_hold, clk, arst_n, p_rsp_hold, "response word changed while stalled")

	`WSFS_ASSERT(a_busy_after_accept, clk, arst_n, p_busy_after_accept, "request taken while busy")

	`WSFS_ASSERT(a_plain_is_last, clk, arst_n, p_plain_is_last, "unreplaced word not marked last")

	`WSFS_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !rsp_valid, "response valid during reset")

endmodule

bind wsclock_frame_sweep_unit wsfs_checker u_wsfs_checker (.*);

// ----- tb/wsclock_frame_sweep_unit_tb.sv -----
// Self-checking bench for wsclock_frame_sweep_unit; depends on wsfs_pkg and its RTL only.
// A directed table, then random phases of frame writes and ring sweeps; each word is
// checked against a victim predictor or, for typed table rows, a fixed expected word.
module wsclock_frame_sweep_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wsfs_pkg::*;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_ITEMS  = 75;
	localparam int HOLD_CYCLES  = 400;

	typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

	typedef struct {
		logic              req_kind;
		logic [IDX_W-1:0]  frame;
		logic [TIME_W-1:0] use_t;
		logic              refb;
		logic [TIME_W-1:0] cur_t;
	} frame_req_t;

	typedef struct {
		logic [IDX_W-1:0]  victim;
		logic [TIME_W-1:0] stamp;
		logic              repl;
		logic              last;
	} victim_word_t;

	typedef struct {
		row_kind_t            kind;
		frame_req_t           req;
		logic [CFG_IDX_W-1:0] reg_sel;
		logic [TIME_W-1:0]    reg_val;
		bit                   typed;
		victim_word_t         want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0]    cfg_data;
	logic                 req_valid;
	logic                 req_ready;
	logic                 req_type;
	logic [IDX_W-1:0]     frame_index;
	logic [TIME_W-1:0]    use_time;
	logic                 ref_bit;
	logic [TIME_W-1:0]    current_time;
	logic                 rsp_valid;
	logic                 rsp_ready;
	logic [IDX_W-1:0]     victim_index;
	logic [TIME_W-1:0]    stamp_time;
	logic                 replaced;
	logic                 is_last;

	logic [TIME_W-1:0] frame_use_time [NUM_FRAMES];
	logic              frame_hot [NUM_FRAMES];
	logic [TIME_W-1:0] win_limit;
	logic [IDX_W-1:0]  hand_origin;

	victim_word_t victims_due[$];
	plan_row_t    plan[$];
	int unsigned  mismatches;
	int unsigned  words_seen;
	int unsigned  cycle_count;
	bit           no_idle;

	wsclock_frame_sweep_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.frame_index  (frame_index),
		.use_time     (use_time),
		.ref_bit      (ref_bit),
		.current_time (current_time),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.victim_index (victim_index),
		.stamp_time   (stamp_time),
		.replaced     (replaced),
		.is_last      (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void predict_victims(input frame_req_t r, ref victim_word_t words[$]);
		int unsigned       hand;
		int unsigned       origin;
		int unsigned       hits;
		logic [TIME_W-1:0] t;
		longint            age;
		if (r.req_kind == REQ_WRITE) begin
			if (r.frame < NUM_FRAMES) begin
				frame_use_time[r.frame] = r.use_t;
				frame_hot[r.frame] = r.refb;
			end
			words.push_back('{r.frame, r.use_t, 1'b0, 1'b1});
			return;
		end
		origin = hand_origin % NUM_FRAMES;
		hand = origin;
		t = r.cur_t;
		hits = 0;
		for (int k = 0; k < NUM_FRAMES; k++) begin
			if (frame_hot[hand]) begin
				frame_hot[hand] = 1'b0;
			end else begin
				age = longint'(t) - longint'(frame_use_time[hand]);
				if (age > longint'(win_limit)) begin
					frame_use_time[hand] = t;
					frame_hot[hand] = 1'b1;
					words.push_back('{IDX_W'(hand), t, 1'b1, 1'b0});
					hits++;
					t = t + 1'b1;
				end
			end
			hand = (hand + 1) % NUM_FRAMES;
		end
		if (hits == 0)
			words.push_back('{IDX_W'(origin), r.cur_t, 1'b0, 1'b1});
		else
			words[words.size()-1].last = 1'b1;
	endfunction

	function automatic void plan_req(logic kind, logic [IDX_W-1:0] f, logic [TIME_W-1:0] u,
			logic rb, logic [TIME_W-1:0] c, bit typed, logic [IDX_W-1:0] wv,
			logic [TIME_W-1:0] wt);
		plan_row_t row;
		row.kind = ROW_REQ;
		row.req = '{kind, f, u, rb, c};
		row.reg_sel = CFG_WINDOW_SIZE;
		row.reg_val = '0;
		row.typed = typed;
		row.want = '{wv, wt, 1'b0, 1'b1};
		plan.push_back(row);
	endfunction

	function automatic void plan_cfg(logic [CFG_IDX_W-1:0] sel, logic [TIME_W-1:0] val);
		plan_row_t row;
		row.kind = ROW_REG;
		row.req = '{REQ_WRITE, '0, '0, 1'b0, '0};
		row.reg_sel = sel;
		row.reg_val = val;
		row.typed = 1'b0;
		row.want = '{'0, '0, 1'b0, 1'b0};
		plan.push_back(row);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at word %0d: %s got %0h want %0h", words_seen, what, got, want);
		mismatches++;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (victims_due.size() != 0)
			@(posedge clk);
		repeat (NUM_FRAMES + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [TIME_W-1:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (sel == CFG_WINDOW_SIZE)
			win_limit = val;
		else
			hand_origin = val[IDX_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(input frame_req_t r);
		while (!no_idle && $urandom_range(99) < 22) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= r.req_kind;
		frame_index <= r.frame;
		use_time <= r.use_t;
		ref_bit <= r.refb;
		current_time <= r.cur_t;
		do @(posedge clk); while (!req_ready);
	endtask

	// response side: check each word, stall at random, one long hold-off
	initial begin
		victim_word_t got;
		victim_word_t want;
		int unsigned  hold_left;
		bit           hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				got = '{victim_index, stamp_time, replaced, is_last};
				if (victims_due.size() == 0) begin
					report_mismatch("unexpected word, victim", longint'(got.victim), 0);
				end else begin
					want = victims_due.pop_front();
					if (got.victim !== want.victim)
						report_mismatch("victim_index", longint'(got.victim),
							longint'(want.victim));
					if (got.stamp !== want.stamp)
						report_mismatch("stamp_time", longint'(got.stamp),
							longint'(want.stamp));
					if (got.repl !== want.repl)
						report_mismatch("replaced", longint'(got.repl), longint'(want.repl));
					if (got.last !== want.last)
						report_mismatch("is_last", longint'(got.last), longint'(want.last));
				end
				words_seen++;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!hold_done && words_seen >= 150) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= no_idle || ($urandom_range(99) >= 22);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("wsclock_frame_sweep_unit_tb failed");
		$finish;
	end

	initial begin
		frame_req_t        r;
		victim_word_t      scratch[$];
		logic [TIME_W-1:0] vclk;
		logic [TIME_W-1:0] wv;
		logic [TIME_W-1:0] sd;
		logic [IDX_W-1:0]  low;
		int unsigned       spread;
		mismatches = 0;
		words_seen = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			frame_use_time[i] = '0;
			frame_hot[i] = 1'b0;
		end
		win_limit = WINDOW_RESET;
		hand_origin = START_RESET;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_WINDOW_SIZE;
		cfg_data <= '0;
		req_valid <= 1'b0;
		req_type <= REQ_WRITE;
		frame_index <= '0;
		use_time <= '0;
		ref_bit <= 1'b0;
		current_time <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan_req(REQ_SWEEP, 0, 0, 0, 0, 1, 3, 0);
		plan_req(REQ_SWEEP, 0, 0, 0, 400, 1, 3, 400);
		plan_req(REQ_WRITE, 63, TIME_MAX, 1, 0, 1, 63, TIME_MAX);
		plan_req(REQ_WRITE, 0, TIME_MAX, 0, 0, 1, 0, TIME_MAX);
		plan_req(REQ_WRITE, 7, 0, 1, 0, 1, 7, 0);
		plan_req(REQ_SWEEP, 0, 0, 0, 401, 0, 0, 0);
		plan_req(REQ_SWEEP, 0, 0, 0, TIME_MAX, 0, 0, 0);
		plan_req(REQ_WRITE, 8, 31'h1234_5678, 1, 0, 1, 8, 31'h1234_5678);
		plan_cfg(CFG_WINDOW_SIZE, TIME_MAX);
		plan_req(REQ_SWEEP, 0, 0, 0, 5, 1, 3, 5);
		plan_cfg(CFG_START_FRAME, TIME_MAX);
		plan_req(REQ_SWEEP, 0, 0, 0, TIME_MAX, 1, 7, TIME_MAX);
		plan_cfg(CFG_WINDOW_SIZE, 0);
		plan_cfg(CFG_START_FRAME, 0);
		plan_req(REQ_SWEEP, 0, 0, 0, 1, 0, 0, 0);
		plan_req(REQ_WRITE, 5, 100, 0, 0, 1, 5, 100);
		plan_req(REQ_SWEEP, 0, 0, 0, 100, 0, 0, 0);
		plan_req(REQ_WRITE, 2, 31'h7FFF_FFF0, 0, 0, 1, 2, 31'h7FFF_FFF0);
		plan_req(REQ_SWEEP, 0, 0, 0, 50, 0, 0, 0);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				write_reg(plan[i].reg_sel, plan[i].reg_val);
			end else begin
				send_request(plan[i].req);
				if (plan[i].typed) begin
					predict_victims(plan[i].req, scratch);
					scratch.delete();
					victims_due.push_back(plan[i].want);
				end else begin
					predict_victims(plan[i].req, victims_due);
				end
			end
		end

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin wv = WINDOW_RESET; low = 3; end
				1: begin wv = 0; low = 0; end
				2: begin wv = TIME_MAX; low = 63; end
				3: begin wv = 1; low = 7; end
				4: begin wv = TIME_W'($urandom_range(1, 3000)); low = 8; end
				default: begin wv = TIME_W'($urandom); low = IDX_W'($urandom); end
			endcase
			sd = TIME_W'($urandom);
			sd[IDX_W-1:0] = low;
			write_reg(CFG_WINDOW_SIZE, wv);
			write_reg(CFG_START_FRAME, sd);
			no_idle = (p == 3);
			vclk = (p == 1) ? TIME_MAX - 31'd3000 : TIME_W'($urandom);
			spread = (win_limit > 4000) ? 4000 : win_limit + 40;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				vclk = vclk + TIME_W'($urandom_range(0, spread / 4 + 2));
				if ($urandom_range(99) < 10) begin
					r.req_kind = 1'($urandom);
					r.frame = IDX_W'($urandom);
					r.use_t = TIME_W'($urandom);
					r.refb = 1'($urandom);
					r.cur_t = TIME_W'($urandom);
				end else begin
					r.req_kind = ($urandom_range(99) < 45) ? REQ_WRITE : REQ_SWEEP;
					r.frame = IDX_W'($urandom_range(0, NUM_FRAMES - 1));
					r.use_t = vclk - TIME_W'($urandom_range(0, spread));
					r.refb = 1'($urandom);
					r.cur_t = vclk;
				end
				send_request(r);
				predict_victims(r, victims_due);
			end
		end
		no_idle = 1'b0;

		settle();
		if (mismatches == 0)
			$display("wsclock_frame_sweep_unit_tb passed");
		else
			$display("wsclock_frame_sweep_unit_tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/wsfs_pkg.sv
src/wsfs_ctrl.sv
src/wsfs_datapath.sv
src/wsclock_frame_sweep_unit.sv
src/wsfs_checker.sv
tb/wsclock_frame_sweep_unit_tb.sv
